/* hw/rtl/fbpa_pkg.sv */
// Package for the fixed block pool allocator: payload structs, status codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
package fbpa_pkg;

    // Default sizing of the pool.
    localparam int FBPA_BLOCK_BYTES     = 16;
    localparam int FBPA_BLOCKS_PER_PAGE = 256;
    localparam int FBPA_MAX_PAGES       = 4;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_BASE_ADDRESS = 1'b0;

    // Request payload.
    typedef struct packed {
        logic        req_type;
        logic [15:0] request_size;
        logic [31:0] free_address;
    } t_in;

    // Result payload.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] block_address;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_DIVIDE,
        S_SPLIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // latch the request and its pool offset
        logic    take_alloc;  // choose a page, open it if needed, read the stack top
        logic    pop;         // commit the pop and keep the block index
        logic    mul;         // start the offset-to-block division
        logic    divide;      // correct the quotient into a global block number
        logic    push;        // push the freed index unless the stack is full
        logic    emit;        // load the result register
        t_status status;      // status of the result being emitted
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic too_large;
        logic is_free;
        logic found;
        logic can_open;
        logic in_pool;
        logic full;
    } t_dp_sts;

endpackage

/* hw/rtl/fbpa_ctrl.sv */
// Controller state machine of the fixed block pool allocator.
// Depends on fbpa_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts.
module fbpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fbpa_pkg::t_dp_sts i_sts,
    output fbpa_pkg::t_dp_cmd o_cmd
);
    import fbpa_pkg::*;

    t_state  r_state,  n_state;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;

    // State, pending status and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.too_large) begin
                    n_status = ST_TOO_LARGE;
                    n_state  = S_DONE;
                end else if (!i_sts.is_free) begin
                    if (i_sts.found || i_sts.can_open) begin
                        o_cmd.take_alloc = 1'b1;
                        n_state          = S_POP;
                    end else begin
                        n_status = ST_EXHAUSTED;
                        n_state  = S_DONE;
                    end
                end else if (i_sts.in_pool) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIVIDE;
                end else begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_DONE;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_status  = ST_OK;
                n_state   = S_DONE;
            end
            S_DIVIDE: begin
                o_cmd.divide = 1'b1;
                n_state      = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.push = 1'b1;
                n_status   = i_sts.full ? ST_FULL : ST_OK;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // Wait here while the previous result is still held.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/fbpa_dp.sv */
// Datapath of the fixed block pool allocator: request registers, page counts,
// the free-index stack memory, offset division and the result register.
// Depends on fbpa_pkg; controlled by fbpa_ctrl.
module fbpa_dp #(
    parameter int BLOCK_BYTES     = fbpa_pkg::FBPA_BLOCK_BYTES,
    parameter int BLOCKS_PER_PAGE = fbpa_pkg::FBPA_BLOCKS_PER_PAGE,
    parameter int MAX_PAGES       = fbpa_pkg::FBPA_MAX_PAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_base_address,
    input  fbpa_pkg::t_in     i_in,
    input  fbpa_pkg::t_dp_cmd i_cmd,
    output fbpa_pkg::t_dp_sts o_sts,
    output fbpa_pkg::t_out    o_out
);
    import fbpa_pkg::*;

    localparam int PAGE_BYTES = BLOCK_BYTES * BLOCKS_PER_PAGE;
    localparam int IDX_W      = $clog2(BLOCKS_PER_PAGE);
    localparam int CNT_W      = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int OPEN_W     = $clog2(MAX_PAGES + 1);
    localparam int MEM_DEPTH  = MAX_PAGES * BLOCKS_PER_PAGE;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int OFF_W      = $clog2(MAX_PAGES * PAGE_BYTES);
    localparam int PROD_W     = 2 * OFF_W + 1;
    // Reciprocal of the block size, scaled by 2^OFF_W and rounded down.
    localparam logic [OFF_W:0] RECIP = (OFF_W + 1)'((64'd1 << OFF_W) / BLOCK_BYTES);

    // Request registers.
    logic              r_type;
    logic [15:0]       r_size;
    logic [31:0]       r_off;
    logic [PROD_W-1:0] r_prod;
    logic [AW-1:0]     r_g;
    logic [PAGE_W-1:0] r_page;
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_rdata;
    t_out              r_out;

    // Page state: opened pages, stack fill counts and low-water marks.
    // Stack positions at or above a page's low-water mark have been written
    // since reset; those below it still hold their own position.
    logic [OPEN_W-1:0] r_opened;
    logic [CNT_W-1:0]  r_count [MAX_PAGES];
    logic [CNT_W-1:0]  r_mark  [MAX_PAGES];

    // Free-index stacks of all pages.
    logic [IDX_W-1:0]  r_mem [MEM_DEPTH];

    logic              found;
    logic [PAGE_W-1:0] found_page;
    logic [PAGE_W-1:0] alloc_page;
    logic [IDX_W-1:0]  alloc_pos;
    logic [IDX_W-1:0]  pop_idx;
    logic [OFF_W-1:0]  q0;
    logic [OFF_W-1:0]  rem;
    logic [PAGE_W-1:0] sp_page;
    logic [IDX_W-1:0]  sp_idx;
    logic              full;
    logic              in_pool;
    logic [31:0]       alloc_addr;

    function automatic logic [AW-1:0] stack_addr(logic [PAGE_W-1:0] page,
                                                 logic [IDX_W-1:0] pos);
        return AW'(page) * AW'(BLOCKS_PER_PAGE) + AW'(pos);
    endfunction

    // First opened page with a free block.
    always_comb begin
        found      = 1'b0;
        found_page = '0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            if (!found && (OPEN_W'(p) < r_opened) && (r_count[p] != '0)) begin
                found      = 1'b1;
                found_page = PAGE_W'(p);
            end
        end
    end

    // Page and stack position of an allocation; a newly opened page is full.
    assign alloc_page = found ? found_page : r_opened[PAGE_W-1:0];
    assign alloc_pos  = found ? IDX_W'(r_count[found_page] - CNT_W'(1))
                              : IDX_W'(BLOCKS_PER_PAGE - 1);

    // Popped index: memory data only where the position was written.
    assign pop_idx = (CNT_W'(r_pos) >= r_mark[r_page]) ? r_rdata : r_pos;

    // Pool offset lies inside the opened pages.
    assign in_pool = {1'b0, r_off} < (33'(r_opened) * 33'(PAGE_BYTES));

    // Quotient estimate, never more than one below the true block number.
    assign q0  = r_prod[PROD_W-2 -: OFF_W];
    assign rem = r_off[OFF_W-1:0] - q0 * OFF_W'(BLOCK_BYTES);

    // Page and index of the global block number being freed.
    always_comb begin
        sp_page = '0;
        for (int k = 1; k < MAX_PAGES; k++) begin
            if (r_g >= AW'(k * BLOCKS_PER_PAGE)) begin
                sp_page = PAGE_W'(k);
            end
        end
    end
    assign sp_idx = IDX_W'(r_g - AW'(sp_page) * AW'(BLOCKS_PER_PAGE));
    assign full   = (r_count[sp_page] >= CNT_W'(BLOCKS_PER_PAGE));

    // Byte address of the allocated block.
    assign alloc_addr = i_base_address + 32'(r_page) * 32'(PAGE_BYTES)
                      + 32'(r_idx) * 32'(BLOCK_BYTES);

    // Request and arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_in.req_type;
            r_size <= i_in.request_size;
            r_off  <= i_in.free_address - i_base_address;
        end
        if (i_cmd.take_alloc) begin
            r_page <= alloc_page;
            r_pos  <= alloc_pos;
        end
        if (i_cmd.pop) begin
            r_idx <= pop_idx;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_off[OFF_W-1:0]) * PROD_W'(RECIP);
        end
        if (i_cmd.divide) begin
            r_g <= AW'((rem >= OFF_W'(BLOCK_BYTES)) ? q0 + OFF_W'(1) : q0);
        end
    end

    // Stack memory: read the top on allocate, write the freed index on push.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_alloc) begin
            r_rdata <= r_mem[stack_addr(alloc_page, alloc_pos)];
        end
        if (i_cmd.push && !full) begin
            r_mem[stack_addr(sp_page, IDX_W'(r_count[sp_page]))] <= sp_idx;
        end
    end

    // Page state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opened <= '0;
            for (int p = 0; p < MAX_PAGES; p++) begin
                r_count[p] <= CNT_W'(BLOCKS_PER_PAGE);
                r_mark[p]  <= CNT_W'(BLOCKS_PER_PAGE);
            end
        end else begin
            if (i_cmd.take_alloc && !found) begin
                r_opened <= r_opened + OPEN_W'(1);
            end
            if (i_cmd.pop) begin
                r_count[r_page] <= CNT_W'(r_pos);
                if (CNT_W'(r_pos) < r_mark[r_page]) begin
                    r_mark[r_page] <= CNT_W'(r_pos);
                end
            end
            if (i_cmd.push && !full) begin
                r_count[sp_page] <= r_count[sp_page] + CNT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status <= 3'(i_cmd.status);
            r_out.block_address <= ((i_cmd.status == ST_OK) && (r_type == REQ_ALLOC))
                                   ? alloc_addr : 32'd0;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts           = '0;
        o_sts.too_large = {1'b0, r_size} > 17'(BLOCK_BYTES);
        o_sts.is_free   = (r_type == REQ_FREE);
        o_sts.found     = found;
        o_sts.can_open  = (r_opened < OPEN_W'(MAX_PAGES));
        o_sts.in_pool   = in_pool;
        o_sts.full      = full;
    end

    assign o_out = r_out;

endmodule

/* hw/rtl/fixed_block_pool_allocator_unit.sv */
// Fixed block pool allocator: pool of pages with one free-index stack per page.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready, payload i_in)
//   and each gives exactly one result on the output channel (o_out_valid /
//   i_out_ready, payload o_out). An allocate pops a block index from the first
//   opened page with a free block, opening the next page when none has one; a
//   free pushes the index of the addressed block back onto its page's stack.
//   The base address is written through the APB-style port at byte address 0.
// Steps: a rejected request goes from the check straight to the result; an
//   allocate reads the stack top synchronously and then pops it; an in-pool
//   free multiplies the offset by the reciprocal of the block size, corrects
//   the quotient and pushes the index. One request is in flight at a time, and
//   a new request can be taken in the same cycle as the result appears.
// A result waits in the output register while the receiver stalls; the block
//   holds its final step until that register frees up, and takes no new request.
// Reset empties the output register, closes all pages and sets each page count
//   to full; the stack memory needs no clearing pass.
module fixed_block_pool_allocator_unit #(
    parameter int BLOCK_BYTES     = fbpa_pkg::FBPA_BLOCK_BYTES,
    parameter int BLOCKS_PER_PAGE = fbpa_pkg::FBPA_BLOCKS_PER_PAGE,
    parameter int MAX_PAGES       = fbpa_pkg::FBPA_MAX_PAGES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fbpa_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fbpa_pkg::t_out o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import fbpa_pkg::*;

    logic [31:0] r_base;
    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic        reg_index;

    // Configuration register, one word at byte address 0.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && pready
                     && (reg_index == REG_BASE_ADDRESS)) begin
            r_base <= pwdata;
        end
    end

    assign prdata = (reg_index == REG_BASE_ADDRESS) ? r_base : 32'd0;

    // Controller.
    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath.
    fbpa_dp #(
        .BLOCK_BYTES     (BLOCK_BYTES),
        .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE),
        .MAX_PAGES       (MAX_PAGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_address (r_base),
        .i_in           (i_in),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out          (o_out)
    );

endmodule

/* hw/rtl/fbpa_checker.sv */
// Port-level checker for the fixed block pool allocator, with its bind statement.
// Depends on fbpa_pkg; attaches to fixed_block_pool_allocator_unit.
module fbpa_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input fbpa_pkg::t_out o_out
);
    import fbpa_pkg::*;

    // A result held back by the receiver stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Only a successful transaction carries a block address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_OK)) |-> (o_out.block_address == 32'd0))
        else $error("non-zero address on a failed transaction");

    // One request at a time: no accept in the cycle after an accept.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
